/* rtl/two_level_branch_predictor_assert.svh */
// Assertion macros shared by the predictor RTL.
// Each macro assumes clk and rst are in scope; ASSERT_OFF compiles them out.
`ifndef TWO_LEVEL_BRANCH_PREDICTOR_ASSERT_SVH
`define TWO_LEVEL_BRANCH_PREDICTOR_ASSERT_SVH

`ifndef ASSERT_OFF

`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(label, cond, msg)
`define ASSERT_IMPLIES(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

/* rtl/tlbp_pkg.sv */
// Package for the two-level branch predictor: widths, codes, FSM states,
// and the command/status structs between controller and datapath. No dependencies.
package tlbp_pkg;

  localparam int PC_W       = 32;
  localparam int FUNC_W     = 3;
  localparam int HIST_W     = 16;
  localparam int HIST_MAX   = 16;
  localparam int CNT_AW     = 12;
  localparam int CNT_DEPTH  = 1 << CNT_AW;
  localparam int HROW_AW    = 10;
  localparam int HROW_DEPTH = 1 << HROW_AW;
  localparam int LRL_W      = 4;
  localparam int LEN_W      = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [LEN_W-1:0] HIST_LEN_RESET = LEN_W'(12);
  localparam logic [1:0] CTR_WEAK_NT = 2'd1;
  localparam logic [1:0] CTR_WEAK_T  = 2'd2;
  localparam logic [1:0] CTR_MAX     = 2'd3;
  localparam logic [1:0] CTR_MIN     = 2'd0;

  typedef enum logic [FUNC_W-1:0] {
    FN_LOOKUP  = 3'd0,
    FN_SPEC    = 3'd1,
    FN_UPDATE  = 3'd2,
    FN_RECOVER = 3'd3,
    FN_FLUSH   = 3'd4
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOCAL_ROWS = 2'd0,
    CFG_HIST_LEN   = 2'd1,
    CFG_HASH_MODE  = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HREAD,
    S_EXEC,
    S_OUT
  } state_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic rd;
    logic exec;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic is_lookup;
  } stat_t;

endpackage

/* rtl/tlbp_req_if.sv */
// Request channel of the branch predictor: valid/ready plus request fields.
// Depends on tlbp_pkg.
interface tlbp_req_if;
  import tlbp_pkg::*;

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [PC_W-1:0]   pc;
  logic              outcome;
  logic              predicted;
  logic [HIST_W-1:0] saved_history;
  logic [CNT_AW-1:0] counter_slot;

  modport source (output valid, func, pc, outcome, predicted, saved_history, counter_slot,
                  input ready);
  modport sink (input valid, func, pc, outcome, predicted, saved_history, counter_slot,
                output ready);
endinterface

/* rtl/tlbp_rsp_if.sv */
// Response channel of the branch predictor: valid/ready plus prediction fields.
// Depends on tlbp_pkg.
interface tlbp_rsp_if;
  import tlbp_pkg::*;

  logic              valid;
  logic              ready;
  logic              pred_taken;
  logic [CNT_AW-1:0] counter_index;
  logic [HIST_W-1:0] history_seen;

  modport source (output valid, pred_taken, counter_index, history_seen, input ready);
  modport sink (input valid, pred_taken, counter_index, history_seen, output ready);
endinterface

/* rtl/two_level_branch_predictor.sv */
// Channel  Dir  Handshake     Payload
// req      in   valid/ready   func, pc, outcome, predicted, saved_history, counter_slot
// rsp      out  valid/ready   pred_taken, counter_index, history_seen (lookup only)
// cfg      in   cfg_we        cfg_index, cfg_data
// After reset the tables are initialized while req.ready stays low.
// A request steps through accept, history read and execute; a lookup then
// holds its response until rsp.ready. The dependent table reads set this
// order: history row first, then the counter at the hashed index.
// Depends on tlbp_pkg, tlbp_req_if, tlbp_rsp_if, tlbp_ctrl, tlbp_dp.
module two_level_branch_predictor (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [tlbp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tlbp_pkg::CFG_DATA_W-1:0] cfg_data,
  tlbp_req_if.sink                        req,
  tlbp_rsp_if.source                      rsp
);
  import tlbp_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  tlbp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tlbp_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .func          (req.func),
    .pc            (req.pc),
    .outcome       (req.outcome),
    .predicted     (req.predicted),
    .saved_history (req.saved_history),
    .counter_slot  (req.counter_slot),
    .pred_taken    (rsp.pred_taken),
    .counter_index (rsp.counter_index),
    .history_seen  (rsp.history_seen)
  );

endmodule

/* rtl/tlbp_ctrl.sv */
// Controller FSM: table clear after reset, request sequencing, response hold.
// Depends on tlbp_pkg and two_level_branch_predictor_assert.svh.
`include "two_level_branch_predictor_assert.svh"

module tlbp_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  tlbp_pkg::stat_t stat,
  output tlbp_pkg::cmd_t  cmd
);
  import tlbp_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clr_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_HREAD;
        end
      end
      S_HREAD: begin
        cmd.rd     = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = stat.is_lookup ? S_OUT : S_IDLE;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  `ASSERT_ALWAYS(a_no_overlap, !(in_ready && out_valid), "request taken while response pending")
  `ASSERT_IMPLIES(a_exec_order, state == S_EXEC, $past(state) == S_HREAD, "exec without read")
  `ASSERT_IMPLIES(a_rsp_lookup, out_valid, stat.is_lookup, "response for non-lookup request")

endmodule

/* rtl/tlbp_dp.sv */
// Datapath: config registers, history row and counter tables, index hash,
// counter training and history rewrite. Depends on tlbp_pkg.
module tlbp_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  tlbp_pkg::cmd_t                    cmd,
  output tlbp_pkg::stat_t                   stat,
  input  logic                              cfg_we,
  input  logic [tlbp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tlbp_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [tlbp_pkg::FUNC_W-1:0]       func,
  input  logic [tlbp_pkg::PC_W-1:0]         pc,
  input  logic                              outcome,
  input  logic                              predicted,
  input  logic [tlbp_pkg::HIST_W-1:0]       saved_history,
  input  logic [tlbp_pkg::CNT_AW-1:0]       counter_slot,
  output logic                              pred_taken,
  output logic [tlbp_pkg::CNT_AW-1:0]       counter_index,
  output logic [tlbp_pkg::HIST_W-1:0]       history_seen
);
  import tlbp_pkg::*;

  logic [LRL_W-1:0]  lrl;
  logic [LEN_W-1:0]  hlen;
  logic              hmode;

  func_t             f_r;
  logic [PC_W-1:0]   pc_r;
  logic              oc_r;
  logic              pr_r;
  logic [HIST_W-1:0] saved_r;
  logic [CNT_AW-1:0] slot_r;

  logic [CNT_AW-1:0] clr_cnt;
  logic [HIST_W-1:0] hist_rd;
  logic [1:0]        cnt_rd;
  logic [CNT_AW-1:0] idx_r;
  logic [HIST_W-1:0] hist_out;

  logic [HIST_W-1:0] hmem [HROW_DEPTH];
  logic [1:0]        cmem [CNT_DEPTH];

  logic [LEN_W-1:0]   len;
  logic [LEN_W-1:0]   sh;
  logic [HIST_W-1:0]  hmask;
  logic [HROW_AW-1:0] row_mask;
  logic [HROW_AW-1:0] row;
  logic [CNT_AW-1:0]  idx;
  logic [CNT_AW-1:0]  c_ra;
  logic [1:0]         trained;
  logic               global_hist;

  logic               h_we;
  logic [HROW_AW-1:0] h_wa;
  logic [HIST_W-1:0]  h_wd;
  logic               c_we;
  logic [CNT_AW-1:0]  c_wa;
  logic [1:0]         c_wd;

  always_ff @(posedge clk) begin
    if (rst) begin
      lrl   <= '0;
      hlen  <= HIST_LEN_RESET;
      hmode <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_LOCAL_ROWS: lrl   <= cfg_data[LRL_W-1:0];
        CFG_HIST_LEN:   hlen  <= cfg_data[LEN_W-1:0];
        CFG_HASH_MODE:  hmode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear) begin
      clr_cnt <= clr_cnt + CNT_AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      f_r     <= func_t'(func);
      pc_r    <= pc;
      oc_r    <= outcome;
      pr_r    <= predicted;
      saved_r <= saved_history;
      slot_r  <= counter_slot;
    end
    if (cmd.exec) begin
      idx_r    <= idx;
      hist_out <= hist_rd;
    end
  end

  always_comb begin
    len         = (hlen > LEN_W'(HIST_MAX)) ? LEN_W'(HIST_MAX) : hlen;
    sh          = (LEN_W'(CNT_AW) > len) ? (LEN_W'(CNT_AW) - len) : '0;
    hmask       = ~({HIST_W{1'b1}} << len);
    row_mask    = (lrl >= LRL_W'(HROW_AW)) ? {HROW_AW{1'b1}} : ~({HROW_AW{1'b1}} << lrl);
    row         = pc_r[HROW_AW-1:0] & row_mask;
    global_hist = (lrl == '0);
    if (hmode) begin
      idx = pc_r[CNT_AW-1:0] ^ (hist_rd[CNT_AW-1:0] << sh);
    end else begin
      idx = (pc_r[CNT_AW-1:0] << len) | hist_rd[CNT_AW-1:0];
    end
    c_ra = cmd.exec ? idx : slot_r;
    if (oc_r) begin
      trained = (cnt_rd == CTR_MAX) ? CTR_MAX : cnt_rd + 2'd1;
    end else begin
      trained = (cnt_rd == CTR_MIN) ? CTR_MIN : cnt_rd - 2'd1;
    end
  end

  always_comb begin
    h_we = 1'b0;
    h_wa = row;
    h_wd = '0;
    c_we = 1'b0;
    c_wa = slot_r;
    c_wd = trained;
    if (cmd.clear) begin
      h_we = 1'b1;
      h_wa = clr_cnt[HROW_AW-1:0];
      c_we = 1'b1;
      c_wa = clr_cnt;
      c_wd = clr_cnt[0] ? CTR_WEAK_T : CTR_WEAK_NT;
    end else if (cmd.exec) begin
      case (f_r)
        FN_SPEC: begin
          h_we = 1'b1;
          h_wd = {hist_rd[HIST_W-2:0], pr_r} & hmask;
        end
        FN_UPDATE: begin
          h_we = 1'b1;
          h_wd = {saved_r[HIST_W-2:0], oc_r} & hmask;
          c_we = 1'b1;
        end
        FN_RECOVER: begin
          h_we = global_hist;
          h_wa = '0;
          h_wd = {saved_r[HIST_W-2:0], oc_r} & hmask;
        end
        FN_FLUSH: begin
          h_we = global_hist;
          h_wa = '0;
          h_wd = saved_r & hmask;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (h_we) begin
      hmem[h_wa] <= h_wd;
    end
    if (cmd.rd) begin
      hist_rd <= hmem[row];
    end
  end

  always_ff @(posedge clk) begin
    if (c_we) begin
      cmem[c_wa] <= c_wd;
    end
    if (cmd.rd || cmd.exec) begin
      cnt_rd <= cmem[c_ra];
    end
  end

  assign stat.clr_done  = (clr_cnt == {CNT_AW{1'b1}});
  assign stat.is_lookup = (f_r == FN_LOOKUP);

  assign pred_taken    = cnt_rd[1];
  assign counter_index = idx_r;
  assign history_seen  = hist_out;

endmodule
